// ===== rtl/dhm_pkg.sv =====
// ----------------------------------------------------------------------------
// dhm_pkg
// Shared types, codes and constants of the desk height move controller.
// ----------------------------------------------------------------------------
package dhm_pkg;

  localparam int DUTY_BITS = 8;
  localparam logic [7:0] DUTY_MAX = 8'(((1 << DUTY_BITS) - 1));

  localparam logic signed [15:0] MIN_TARGET = 16'sd600;
  localparam logic signed [15:0] MAX_TARGET = 16'sd1300;

  // ms per second, for the speed cross-multiplication
  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic signed [1:0] DIR_STOP = 2'sb00;
  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_DONE         = 4'd1,
    EV_OVERSHOOT    = 4'd2,
    EV_BACKWARDS    = 4'd3,
    EV_TOO_SLOW     = 4'd4,
    EV_TIMEOUT      = 4'd5,
    EV_OUT_OF_BOUND = 4'd6,
    EV_INIT_TIMEOUT = 4'd7,
    EV_ALREADY      = 4'd8,
    EV_STOPPED      = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    REG_HEIGHT_TOL  = 3'd0,
    REG_WINDOW_MS   = 3'd1,
    REG_SPEED_MIN   = 3'd2,
    REG_FAIL_LIMIT  = 3'd3,
    REG_SLOW_START  = 3'd4,
    REG_SLOW_END    = 3'd5,
    REG_DUTY_FULL   = 3'd6,
    REG_DUTY_SLOW   = 3'd7
  } reg_index_t;

  localparam logic [9:0]  RST_HEIGHT_TOL = 10'd5;
  localparam logic [15:0] RST_WINDOW_MS  = 16'd200;
  localparam logic [15:0] RST_SPEED_MIN  = 16'd10;
  localparam logic [7:0]  RST_FAIL_LIMIT = 8'd3;
  localparam logic [11:0] RST_SLOW_START = 12'd100;
  localparam logic [11:0] RST_SLOW_END   = 12'd20;
  localparam logic [7:0]  RST_DUTY_FULL  = 8'd255;
  localparam logic [7:0]  RST_DUTY_SLOW  = 8'd100;

  typedef struct packed {
    logic [9:0]  height_tolerance;
    logic [15:0] speed_window_ms;
    logic [15:0] speed_minimum;
    logic [7:0]  speed_fail_limit;
    logic [11:0] slowdown_start;
    logic [11:0] slowdown_end;
    logic [7:0]  duty_full;
    logic [7:0]  duty_slow;
  } cfg_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] target_height;
    logic signed [15:0] distance;
    logic [31:0]        sample_time;
    logic               sample_valid;
  } item_t;

  typedef struct packed {
    logic signed [1:0] direction;
    logic [7:0]        up_duty;
    logic [7:0]        down_duty;
    event_t            event_code;
  } result_t;

  // request to the slope divider
  typedef struct packed {
    logic        go;
    logic        degenerate;
    logic [7:0]  num;
    logic [11:0] den;
  } div_req_t;

endpackage

// ===== rtl/dhm_slope_div.sv =====
// ----------------------------------------------------------------------------
// dhm_slope_div
// Restoring divider for the ramp slope, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhm_slope_div (
  input  logic               clk,
  input  logic               rst,
  input  dhm_pkg::div_req_t  req,
  output logic [7:0]         slope,
  output logic               busy
);

  logic [11:0] rem;
  logic [7:0]  numq;
  logic [2:0]  cnt;
  logic [12:0] trial;
  logic        fits;

  assign trial = {rem, numq[7]};
  assign fits  = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.go) begin
      busy <= !req.degenerate;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  // operands stay stable while busy, they are snapshotted by the core
  always_ff @(posedge clk) begin
    if (req.go) begin
      rem  <= '0;
      numq <= req.degenerate ? 8'd0 : req.num;
    end else if (busy) begin
      if (fits) begin
        rem  <= 12'(trial - {1'b0, req.den});
        numq <= {numq[6:0], 1'b1};
      end else begin
        rem  <= trial[11:0];
        numq <= {numq[6:0], 1'b0};
      end
    end
  end

  assign slope = numq;

endmodule

// ===== rtl/dhm_core.sv =====
// ----------------------------------------------------------------------------
// dhm_core
// Move state and the per-item decision logic: start, sample and stop.
// ----------------------------------------------------------------------------
module dhm_core (
  input  logic              clk,
  input  logic              rst,
  input  dhm_pkg::cfg_t     cfg,
  input  logic              fire,
  input  dhm_pkg::item_t    item,
  output dhm_pkg::result_t  res,
  output logic              busy
);

  logic signed [1:0]  dir, dir_next;
  logic signed [15:0] tgt_store, tgt_store_next;
  logic signed [15:0] wsd, wsd_next;
  logic [31:0]        wst, wst_next;
  logic [7:0]         fc, fc_next;
  logic [7:0]         up, up_next;
  logic [7:0]         dn, dn_next;
  dhm_pkg::event_t    ev;
  logic               div_go;

  // slope operands, frozen when a move begins
  logic [7:0]         op_full, op_slow;
  logic [11:0]        op_start, op_end;
  dhm_pkg::div_req_t  req;
  logic [7:0]         slope;

  logic signed [16:0] start_sdiff, samp_sdiff, delta;
  logic [16:0]        start_diff, diff, mag;
  logic               want_up, overshoot;
  logic [31:0]        elapsed;
  logic               window_due;
  logic [26:0]        mag_scaled;
  logic [47:0]        rate_floor;
  logic               slow, moved_up, bad_dir;
  logic [7:0]         fc_inc;
  logic               fail_hit;
  logic               near, in_ramp;
  logic [11:0]        ramp_off;
  logic [19:0]        ramp_prod;
  logic [20:0]        ramp_level, level;
  logic [7:0]         duty;
  logic               drive;

  assign start_sdiff = 17'(item.target_height) - 17'(item.distance);
  assign start_diff  = start_sdiff[16] ? 17'(-start_sdiff) : 17'(start_sdiff);
  assign samp_sdiff  = 17'(tgt_store) - 17'(item.distance);
  assign diff        = samp_sdiff[16] ? 17'(-samp_sdiff) : 17'(samp_sdiff);
  assign want_up     = tgt_store > item.distance;
  assign overshoot   = want_up ? (dir != dhm_pkg::DIR_UP) : (dir != dhm_pkg::DIR_DOWN);

  // speed check over the window: |delta| * 1000 < minimum * elapsed
  assign elapsed    = item.sample_time - wst;
  assign window_due = elapsed >= {16'd0, cfg.speed_window_ms};
  assign delta      = 17'(item.distance) - 17'(wsd);
  assign mag        = delta[16] ? 17'(-delta) : 17'(delta);
  assign mag_scaled = {10'd0, mag} * {17'd0, dhm_pkg::MS_PER_S};
  assign rate_floor = {32'd0, cfg.speed_minimum} * {16'd0, elapsed};
  assign slow       = {21'd0, mag_scaled} < rate_floor;
  assign moved_up   = !delta[16] && (delta != 17'sd0);
  assign bad_dir    = (dir == dhm_pkg::DIR_UP) ? !moved_up : moved_up;
  assign fc_inc     = (fc != 8'hFF) ? fc + 8'd1 : fc;
  assign fail_hit   = fc_inc >= cfg.speed_fail_limit;

  // duty ramp near the target
  assign near       = diff <= {5'd0, cfg.slowdown_end};
  assign in_ramp    = diff <= {5'd0, cfg.slowdown_start};
  assign ramp_off   = diff[11:0] - cfg.slowdown_end;
  assign ramp_prod  = {12'd0, slope} * {8'd0, ramp_off};
  assign ramp_level = {13'd0, cfg.duty_slow} + {1'b0, ramp_prod};
  assign level      = near    ? {13'd0, cfg.duty_slow} :
                      in_ramp ? ramp_level : {13'd0, cfg.duty_full};
  assign duty       = (level > {13'd0, dhm_pkg::DUTY_MAX}) ? 8'd0 :
                      dhm_pkg::DUTY_MAX - level[7:0];

  always_comb begin
    dir_next       = dir;
    tgt_store_next = tgt_store;
    wsd_next       = wsd;
    wst_next       = wst;
    fc_next        = fc;
    up_next        = up;
    dn_next        = dn;
    ev             = dhm_pkg::EV_NONE;
    div_go         = 1'b0;
    drive          = 1'b0;
    case (item.command)
      dhm_pkg::CMD_START: begin
        dir_next = dhm_pkg::DIR_STOP;
        up_next  = dhm_pkg::DUTY_MAX;
        dn_next  = dhm_pkg::DUTY_MAX;
        if (item.target_height < dhm_pkg::MIN_TARGET ||
            item.target_height > dhm_pkg::MAX_TARGET) begin
          ev = dhm_pkg::EV_OUT_OF_BOUND;
        end else begin
          tgt_store_next = item.target_height;
          if (!item.sample_valid) begin
            ev = dhm_pkg::EV_INIT_TIMEOUT;
          end else if (start_diff < {7'd0, cfg.height_tolerance}) begin
            ev = dhm_pkg::EV_ALREADY;
          end else begin
            dir_next = (item.target_height > item.distance) ?
                       dhm_pkg::DIR_UP : dhm_pkg::DIR_DOWN;
            fc_next  = '0;
            wsd_next = item.distance;
            wst_next = item.sample_time;
            div_go   = 1'b1;
          end
        end
      end
      dhm_pkg::CMD_SAMPLE: begin
        if (dir != dhm_pkg::DIR_STOP) begin
          if (!item.sample_valid) begin
            ev = dhm_pkg::EV_TIMEOUT;
          end else if (diff <= {7'd0, cfg.height_tolerance}) begin
            ev = dhm_pkg::EV_DONE;
          end else if (overshoot) begin
            ev = dhm_pkg::EV_OVERSHOOT;
          end else begin
            drive = 1'b1;
            if (window_due) begin
              wsd_next = item.distance;
              wst_next = item.sample_time;
              if (slow || bad_dir) begin
                fc_next = fc_inc;
                if (fail_hit) begin
                  drive = 1'b0;
                  ev = (bad_dir && !slow) ? dhm_pkg::EV_BACKWARDS : dhm_pkg::EV_TOO_SLOW;
                end
              end else begin
                fc_next = '0;
              end
            end
          end
          if (!drive) begin
            dir_next = dhm_pkg::DIR_STOP;
            up_next  = dhm_pkg::DUTY_MAX;
            dn_next  = dhm_pkg::DUTY_MAX;
          end else if (dir == dhm_pkg::DIR_UP) begin
            up_next = duty;
          end else begin
            dn_next = duty;
          end
        end
      end
      dhm_pkg::CMD_STOP: begin
        if (dir != dhm_pkg::DIR_STOP) begin
          ev = dhm_pkg::EV_STOPPED;
        end
        dir_next = dhm_pkg::DIR_STOP;
        up_next  = dhm_pkg::DUTY_MAX;
        dn_next  = dhm_pkg::DUTY_MAX;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir       <= dhm_pkg::DIR_STOP;
      tgt_store <= '0;
      wsd       <= '0;
      wst       <= '0;
      fc        <= '0;
      up        <= dhm_pkg::DUTY_MAX;
      dn        <= dhm_pkg::DUTY_MAX;
    end else if (fire) begin
      dir       <= dir_next;
      tgt_store <= tgt_store_next;
      wsd       <= wsd_next;
      wst       <= wst_next;
      fc        <= fc_next;
      up        <= up_next;
      dn        <= dn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && div_go) begin
      op_full  <= cfg.duty_full;
      op_slow  <= cfg.duty_slow;
      op_start <= cfg.slowdown_start;
      op_end   <= cfg.slowdown_end;
    end
  end

  // the divider is kicked in the cycle after the move begins, from the frozen operands
  logic div_kick;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_kick <= 1'b0;
    end else begin
      div_kick <= fire && div_go;
    end
  end

  assign req.go         = div_kick;
  assign req.degenerate = !(op_full > op_slow && op_start > op_end);
  assign req.num        = op_full - op_slow;
  assign req.den        = op_start - op_end;

  logic div_busy;
  dhm_slope_div u_div (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .slope (slope),
    .busy  (div_busy)
  );

  assign busy = div_kick || div_busy;

  assign res.direction  = dir_next;
  assign res.up_duty    = up_next;
  assign res.down_duty  = dn_next;
  assign res.event_code = ev;

endmodule

// ===== rtl/desk_height_move_controller_unit.sv =====
// ----------------------------------------------------------------------------
// desk_height_move_controller_unit
// Motorized desk move controller with stream input and output channels.
// ----------------------------------------------------------------------------
// Each accepted command item gives exactly one result item, through the input
// register and then the output register. Items are taken one per cycle while
// the output side is free; the one exception is a start that begins a move: it
// holds off the next item while the ramp slope divider runs, one quotient bit
// per cycle, or only for the kick when the ramp settings leave no slope to divide.
// An output register and the input register decouple the two sides,
// so a new item is taken while a finished result still waits. Configuration
// writes take effect at once and do not stall the channels.
module desk_height_move_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // target_height[15:0], distance[31:16], sample_time[63:32]
  input  logic [2:0]  s_tuser,   // command[1:0], sample_valid[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // direction[1:0], up_duty[9:2], down_duty[17:10],
                                 // event_code[21:18], zero[23:22]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dhm_pkg::cfg_t    cfg;
  dhm_pkg::item_t   in_item;
  logic             in_valid;
  dhm_pkg::result_t res;
  logic             busy;
  logic             advance;

  assign advance  = in_valid && (!m_tvalid || m_tready) && !busy;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height_tolerance <= dhm_pkg::RST_HEIGHT_TOL;
      cfg.speed_window_ms  <= dhm_pkg::RST_WINDOW_MS;
      cfg.speed_minimum    <= dhm_pkg::RST_SPEED_MIN;
      cfg.speed_fail_limit <= dhm_pkg::RST_FAIL_LIMIT;
      cfg.slowdown_start   <= dhm_pkg::RST_SLOW_START;
      cfg.slowdown_end     <= dhm_pkg::RST_SLOW_END;
      cfg.duty_full        <= dhm_pkg::RST_DUTY_FULL;
      cfg.duty_slow        <= dhm_pkg::RST_DUTY_SLOW;
    end else if (cfg_we) begin
      case (dhm_pkg::reg_index_t'(cfg_index))
        dhm_pkg::REG_HEIGHT_TOL: cfg.height_tolerance <= cfg_data[9:0];
        dhm_pkg::REG_WINDOW_MS:  cfg.speed_window_ms  <= cfg_data;
        dhm_pkg::REG_SPEED_MIN:  cfg.speed_minimum    <= cfg_data;
        dhm_pkg::REG_FAIL_LIMIT: cfg.speed_fail_limit <= cfg_data[7:0];
        dhm_pkg::REG_SLOW_START: cfg.slowdown_start   <= cfg_data[11:0];
        dhm_pkg::REG_SLOW_END:   cfg.slowdown_end     <= cfg_data[11:0];
        dhm_pkg::REG_DUTY_FULL:  cfg.duty_full        <= cfg_data[7:0];
        dhm_pkg::REG_DUTY_SLOW:  cfg.duty_slow        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command       <= dhm_pkg::cmd_t'(s_tuser[1:0]);
      in_item.sample_valid  <= s_tuser[2];
      in_item.target_height <= s_tdata[15:0];
      in_item.distance      <= s_tdata[31:16];
      in_item.sample_time   <= s_tdata[63:32];
    end
  end

  dhm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (in_item),
    .res  (res),
    .busy (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, res.event_code, res.down_duty, res.up_duty, res.direction};
    end
  end

endmodule

// ===== rtl/dhm_checker.sv =====
// ----------------------------------------------------------------------------
// dhm_checker
// Port-level checks of the desk move controller result stream.
// ----------------------------------------------------------------------------
module dhm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a held result keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // any reported event ends the move with both relays off
  a_event_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21:18] != dhm_pkg::EV_NONE |->
      m_tdata[1:0] == dhm_pkg::DIR_STOP && m_tdata[9:2] == dhm_pkg::DUTY_MAX &&
      m_tdata[17:10] == dhm_pkg::DUTY_MAX)
    else $error("event without halt");

  // stopped means both relays off
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == dhm_pkg::DIR_STOP |->
      m_tdata[9:2] == dhm_pkg::DUTY_MAX && m_tdata[17:10] == dhm_pkg::DUTY_MAX)
    else $error("relay driven while stopped");

  // only the relay of the current direction is driven
  a_one_relay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_tdata[1:0] != dhm_pkg::DIR_UP || m_tdata[17:10] == dhm_pkg::DUTY_MAX) &&
      (m_tdata[1:0] != dhm_pkg::DIR_DOWN || m_tdata[9:2] == dhm_pkg::DUTY_MAX) &&
      (m_tdata[1:0] == dhm_pkg::DIR_STOP || m_tdata[1:0] == dhm_pkg::DIR_UP ||
       m_tdata[1:0] == dhm_pkg::DIR_DOWN))
    else $error("wrong relay driven");

endmodule

bind desk_height_move_controller_unit dhm_checker u_dhm_checker (.*);
